/* src/xed_pkg.sv */
// Shared types, constants and entity tables for the XML entity decoder.
// No dependencies; the core, controller and datapath refer to it by scoped names.
package xed_pkg;

    localparam int unsigned HOLD_DEPTH  = 5;
    localparam int unsigned NUM_ENT     = 5;
    localparam int unsigned ENT_MAX_LEN = 5;

    localparam logic [7:0] AMP_CHAR = 8'h26;

    typedef logic [2:0] count_t;
    typedef logic [NUM_ENT-1:0] ent_vec_t;

    // Entity text after the ampersand, zero padded.
    localparam logic [7:0] ENT_NAME [NUM_ENT][ENT_MAX_LEN] = '{
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // amp;
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},   // gt;
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},   // quot;
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}    // apos;
    };

    localparam count_t ENT_LEN [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};

    localparam logic [7:0] ENT_REPL [NUM_ENT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PASS,
        CMD_REPL,
        CMD_OPEN,
        CMD_EXTEND,
        CMD_SAVE,
        CMD_REPLAY,
        CMD_TAIL
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic open_ok;
        logic full;
        logic extend;
        logic replay_end;
        logic pend_open;
    } status_t;

endpackage

/* src/xed_in_if.sv */
// Input channel of the XML entity decoder: raw byte and end-of-string flag.
// No dependencies.
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* src/xed_out_if.sv */
// Output channel of the XML entity decoder: decoded byte and its flags.
// No dependencies.
interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    modport source (output valid, output out_byte, output run_last, output string_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_last,
                    output ready);
endinterface

/* src/xml_entity_decoder_core.sv */
// Top level of the XML entity decoder: joins controller and datapath to the channels.
// Depends on xed_pkg, xed_in_if, xed_out_if, xed_ctrl and xed_dp.
//
// Use: raw text enters on in_ch one byte per transfer, in_last on the final byte
// of each string. Decoded bytes leave on out_ch; run_last marks the last byte
// caused by one input byte, string_last the final decoded byte of a string.
// The five predefined entities become their single characters; an ampersand
// and up to four following bytes are held while they still start an entity.
// Results are registered: they leave from the output register.
// Throughput: one input byte per cycle while bytes pass, open, extend or
// complete an entity and the receiver does not stall. A broken match runs as
// accept, replay of the held bytes one a cycle from the hold buffer while the
// receiver takes them, then the breaking byte, or a new hold if it opens a match.
// Reset clears the hold count and the output register; the block is then idle.
// When the receiver stalls, the result waits in the output register and no new
// byte is taken until that register is free.
module xml_entity_decoder_core
(
    input  logic      clk,
    input  logic      rst_n,
    xed_in_if.sink    in_ch,
    xed_out_if.source out_ch
);

    xed_pkg::status_t status;
    xed_pkg::cmd_t    cmd;

    xed_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    xed_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_ch.in_byte),
        .in_last     (in_ch.in_last),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_byte    (out_ch.out_byte),
        .run_last    (out_ch.run_last),
        .string_last (out_ch.string_last)
    );

endmodule

/* src/xed_ctrl.sv */
// Controller of the XML entity decoder: sequences accept, replay and tail emission.
// Depends on xed_pkg for the command and status types.
module xed_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  xed_pkg::status_t status,
    output xed_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IN    = 3'b001,
        S_FLUSH = 3'b010,
        S_TAIL  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = xed_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IN:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    if (status.cnt_zero)
                    begin
                        cmd = status.open_ok ? xed_pkg::CMD_OPEN : xed_pkg::CMD_PASS;
                    end
                    else if (status.full)
                    begin
                        cmd = xed_pkg::CMD_REPL;
                    end
                    else if (status.extend)
                    begin
                        cmd = xed_pkg::CMD_EXTEND;
                    end
                    else
                    begin
                        cmd        = xed_pkg::CMD_SAVE;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd = xed_pkg::CMD_REPLAY;
                    if (status.replay_end)
                    begin
                        state_next = status.pend_open ? S_IN : S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (status.out_free)
                begin
                    cmd        = xed_pkg::CMD_TAIL;
                    state_next = S_IN;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/xed_dp.sv */
// Datapath of the XML entity decoder: hold buffer, entity match, output register.
// Depends on xed_pkg for tables, command and status types.
module xed_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  xed_pkg::cmd_t    cmd,
    output xed_pkg::status_t status,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             string_last
);

    logic [7:0]        held_reg [xed_pkg::HOLD_DEPTH];
    xed_pkg::count_t   cnt_reg;
    xed_pkg::count_t   idx_reg;
    xed_pkg::ent_vec_t alive_reg;
    logic [7:0]        pend_byte_reg;
    logic              pend_last_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              string_last_reg;

    xed_pkg::count_t   name_pos;
    xed_pkg::ent_vec_t alive_next;
    xed_pkg::ent_vec_t full_vec;
    logic [7:0]        repl_byte;
    logic              pend_open;
    logic              replay_end;
    logic              load_out;

    always_comb
    begin
        name_pos  = (cnt_reg == '0) ? '0 : cnt_reg - 3'd1;
        repl_byte = '0;
        for (int k = 0; k < xed_pkg::NUM_ENT; k++)
        begin
            alive_next[k] = alive_reg[k] && (xed_pkg::ENT_LEN[k] >= cnt_reg)
                            && (xed_pkg::ENT_NAME[k][name_pos] == in_byte);
            full_vec[k]   = alive_next[k] && (xed_pkg::ENT_LEN[k] == cnt_reg);
            if (full_vec[k])
            begin
                repl_byte = xed_pkg::ENT_REPL[k];
            end
        end
    end

    assign pend_open  = (pend_byte_reg == xed_pkg::AMP_CHAR) && !pend_last_reg;
    assign replay_end = (idx_reg == cnt_reg - 3'd1);
    assign load_out   = cmd inside {xed_pkg::CMD_PASS, xed_pkg::CMD_REPL,
                                    xed_pkg::CMD_REPLAY, xed_pkg::CMD_TAIL};

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.open_ok    = (in_byte == xed_pkg::AMP_CHAR) && !in_last;
    assign status.full       = |full_vec;
    assign status.extend     = (|alive_next) && !in_last
                               && (cnt_reg < 3'(xed_pkg::HOLD_DEPTH));
    assign status.replay_end = replay_end;
    assign status.pend_open  = pend_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd) inside
                xed_pkg::CMD_PASS,
                xed_pkg::CMD_TAIL,
                xed_pkg::CMD_REPL:
                begin
                    cnt_reg <= '0;
                end
                xed_pkg::CMD_OPEN:
                begin
                    cnt_reg <= 3'd1;
                end
                xed_pkg::CMD_EXTEND:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
                xed_pkg::CMD_SAVE:
                begin
                    idx_reg <= '0;
                end
                xed_pkg::CMD_REPLAY:
                begin
                    idx_reg <= idx_reg + 3'd1;
                    if (replay_end)
                    begin
                        cnt_reg <= pend_open ? 3'd1 : 3'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            xed_pkg::CMD_PASS:
            begin
                out_byte_reg    <= in_byte;
                run_last_reg    <= 1'b1;
                string_last_reg <= in_last;
            end
            xed_pkg::CMD_REPL:
            begin
                out_byte_reg    <= repl_byte;
                run_last_reg    <= 1'b1;
                string_last_reg <= in_last;
            end
            xed_pkg::CMD_OPEN:
            begin
                held_reg[0] <= xed_pkg::AMP_CHAR;
                alive_reg   <= '1;
            end
            xed_pkg::CMD_EXTEND:
            begin
                held_reg[cnt_reg] <= in_byte;
                alive_reg         <= alive_next;
            end
            xed_pkg::CMD_SAVE:
            begin
                pend_byte_reg <= in_byte;
                pend_last_reg <= in_last;
            end
            xed_pkg::CMD_REPLAY:
            begin
                out_byte_reg    <= held_reg[idx_reg];
                run_last_reg    <= replay_end && pend_open;
                string_last_reg <= 1'b0;
                alive_reg       <= '1;
            end
            xed_pkg::CMD_TAIL:
            begin
                out_byte_reg    <= pend_byte_reg;
                run_last_reg    <= 1'b1;
                string_last_reg <= pend_last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_last = string_last_reg;

endmodule

/* src/xed_checker.sv */
// Port-level checks for the XML entity decoder, bound to its top level.
// Depends on xml_entity_decoder_core and its channel interfaces.
module xed_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last)
                                    && $stable(string_last))
        else $error("output payload changed while stalled");

    a_str_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_last |-> run_last)
        else $error("string end without run end");

    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input taken while output register is stalled");

    a_quiet_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("transfer in while result still waits");

endmodule

bind xml_entity_decoder_core xed_checker u_xed_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .run_last    (out_ch.run_last),
    .string_last (out_ch.string_last)
);
